[design/psd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psd_pkg
// Types, constants and the level sequence table shared by the probe
// sequence detector modules.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int CHANNELS = 4;
	localparam int CODE_W   = 16;
	localparam int CNT_W    = 4;
	localparam int DV_W     = 16;
	localparam int IDX_W    = 4;
	localparam int SEQ_LEN  = 11;

	localparam logic [CODE_W-1:0] MIDSCALE  = 16'h8000;
	localparam logic signed [11:0] SCALE_MUL = 12'sd1552;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_ENABLE_MASK   = 1'b0,
		CFG_COUNTER_LIMIT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [CODE_W-1:0] sample_a;
		logic [CODE_W-1:0] sample_b;
		logic [CODE_W-1:0] sample_c;
		logic [CODE_W-1:0] sample_d;
	} in_beat_t;

	typedef struct packed {
		logic [CODE_W-1:0]   result_a;
		logic [CODE_W-1:0]   result_b;
		logic [CODE_W-1:0]   result_c;
		logic [CODE_W-1:0]   result_d;
		logic [CHANNELS-1:0] forced_mask;
		logic [7:0]          probe_level;
	} out_beat_t;

	// shared control from the top level to every lane
	typedef struct packed {
		logic             advance;
		logic [1:0]       step;
		logic [CNT_W-1:0] limit;
	} lane_ctl_t;

	// sequence step (1..3) at a given index; out-of-range reads entry 0
	function automatic logic [1:0] seq_step(input logic [IDX_W-1:0] idx);
		logic [1:0] s;
		begin
			case (idx)
				4'd0:    s = 2'd1;
				4'd1:    s = 2'd3;
				4'd2:    s = 2'd2;
				4'd3:    s = 2'd1;
				4'd4:    s = 2'd2;
				4'd5:    s = 2'd1;
				4'd6:    s = 2'd3;
				4'd7:    s = 2'd2;
				4'd8:    s = 2'd1;
				4'd9:    s = 2'd2;
				4'd10:   s = 2'd3;
				default: s = 2'd1;
			endcase
			return s;
		end
	endfunction

endpackage
`default_nettype wire

[design/psd_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psd_lane
// One channel: window test of the scaled probe value, saturating match
// counter and midscale forcing.
// ----------------------------------------------------------------------------
module psd_lane
	import psd_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire lane_ctl_t                ctl,
	input  wire logic [CODE_W-1:0]        code,
	input  wire logic signed [DV_W-1:0]   dv,
	output logic      [CODE_W-1:0]        result,
	output logic                          forced
);

	logic [CNT_W-1:0]       cnt_q;
	logic [CNT_W-1:0]       cnt_nxt;
	logic [CNT_W:0]         cnt_inc;
	logic signed [DV_W-1:0] lo;
	logic signed [DV_W-1:0] hi;
	logic                   match;

	// window bounds (2*step -/+ 1) * 128
	always_comb begin
		lo = $signed({6'd0, ctl.step - 2'd1, 1'b1, 7'd0});
		hi = $signed({6'd0, ctl.step, 1'b1, 7'd0});
	end

	assign match   = (dv > lo) && (dv < hi);
	assign cnt_inc = {1'b0, cnt_q} + 5'd1;

	always_comb begin
		if (match) begin
			cnt_nxt = (cnt_inc < {1'b0, ctl.limit}) ? cnt_inc[CNT_W-1:0] : ctl.limit;
		end else begin
			cnt_nxt = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.advance) begin
			cnt_q <= cnt_nxt;
		end
	end

	assign forced = cnt_nxt > (ctl.limit >> 1);
	assign result = forced ? MIDSCALE : code;

endmodule
`default_nettype wire

[design/probe_sequence_detector_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// probe_sequence_detector_top
// Probe sequence detector: per-frame window match against a fixed level
// sequence, with per-channel counters that force a channel to midscale.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one frame of four offset-binary codes a
//   beat. out_valid/out_stall/out_data carry one result beat per frame: the
//   codes after disable or forcing, the forced mask and the next probe level.
//   cfg_write/cfg_index/cfg_data write enable_mask and counter_limit; write
//   them only while no frame is in flight.
//   A frame accepted into the input stage is registered and scaled there,
//   then tested and counted into the output register at the next advance.
//   Throughput is one frame per cycle while the receiver does not stall;
//   the only per-frame state (counters, step index) updates on each advance.
//   When the receiver stalls, the output register holds its beat and the
//   input stage still fills once, so one extra frame is taken before
//   in_stall rises.
//   Reset clears the counters and step index, sets enable_mask to all ones
//   and counter_limit to 10, and empties both stages.
// ----------------------------------------------------------------------------
module probe_sequence_detector_top
	import psd_pkg::*;
#(
	parameter int LEVEL_DIVISOR = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_beat_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_beat_t                 out_data,
	input  wire logic                 cfg_write,
	input  wire cfg_index_t           cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data
);

	localparam logic signed [DV_W-1:0] LD_S = DV_W'(LEVEL_DIVISOR);
	localparam int LVL1_I = (256 / LEVEL_DIVISOR > 255) ? 255 : 256 / LEVEL_DIVISOR;
	localparam int LVL2_I = (512 / LEVEL_DIVISOR > 255) ? 255 : 512 / LEVEL_DIVISOR;
	localparam int LVL3_I = (768 / LEVEL_DIVISOR > 255) ? 255 : 768 / LEVEL_DIVISOR;
	localparam logic [7:0] LVL1 = 8'(LVL1_I);
	localparam logic [7:0] LVL2 = 8'(LVL2_I);
	localparam logic [7:0] LVL3 = 8'(LVL3_I);

	logic [CHANNELS-1:0] enable_mask_q;
	logic [CNT_W-1:0]    counter_limit_q;
	logic [IDX_W-1:0]    step_q;
	logic [IDX_W-1:0]    step_nxt;

	logic                        valid_s1;
	logic [CODE_W-1:0]           code_s1 [CHANNELS];
	logic signed [DV_W-1:0]      dv_s1   [CHANNELS];

	logic                        out_valid_q;
	out_beat_t                   out_data_q;

	logic                        advance;
	logic                        in_accept;
	logic [CODE_W-1:0]           in_code  [CHANNELS];
	logic [CODE_W-1:0]           res_code [CHANNELS];
	logic [CHANNELS-1:0]         forced;
	lane_ctl_t                   ctl;
	logic [1:0]                  next_step;
	logic [7:0]                  level;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_mask_q   <= '1;
			counter_limit_q <= 4'd10;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ENABLE_MASK:   enable_mask_q   <= cfg_data;
				CFG_COUNTER_LIMIT: counter_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	assign in_code[0] = in_data.sample_a;
	assign in_code[1] = in_data.sample_b;
	assign in_code[2] = in_data.sample_c;
	assign in_code[3] = in_data.sample_d;

	// input stage: disable, then scale to the probe value times the divisor
	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_scale
		logic [CODE_W-1:0]        code_m;
		logic signed [CODE_W-1:0] centered;
		logic signed [27:0]       prod;
		logic signed [DV_W-1:0]   v_ext;

		always_comb begin
			code_m   = enable_mask_q[ch] ? in_code[ch] : MIDSCALE;
			centered = $signed({~code_m[CODE_W-1], code_m[CODE_W-2:0]});
			prod     = 28'(centered) * 28'(SCALE_MUL);
			// floor of prod / 2^16
			v_ext    = DV_W'($signed(prod[27:16]));
		end

		always_ff @(posedge clk) begin
			if (in_accept) begin
				code_s1[ch] <= code_m;
				dv_s1[ch]   <= DV_W'(v_ext * LD_S);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// sequence
	assign step_nxt = (step_q >= IDX_W'(SEQ_LEN - 1)) ? '0 : step_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (advance) begin
			step_q <= step_nxt;
		end
	end

	assign next_step = seq_step(step_nxt);

	always_comb begin
		case (next_step)
			2'd2:    level = LVL2;
			2'd3:    level = LVL3;
			default: level = LVL1;
		endcase
	end

	assign ctl.advance = advance;
	assign ctl.step    = seq_step(step_q);
	assign ctl.limit   = counter_limit_q;

	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
		psd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.code   (code_s1[ch]),
			.dv     (dv_s1[ch]),
			.result (res_code[ch]),
			.forced (forced[ch])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.result_a    <= res_code[0];
			out_data_q.result_b    <= res_code[1];
			out_data_q.result_c    <= res_code[2];
			out_data_q.result_d    <= res_code[3];
			out_data_q.forced_mask <= forced;
			out_data_q.probe_level <= level;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= IDX_W'(SEQ_LEN - 1))
		else $error("step index out of range");

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked frame");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced frame did not reach the output register");

	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(step_q))
		else $error("step index moved without an advance");

endmodule
`default_nettype wire

[tb/probe_sequence_detector_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// probe_sequence_detector_top_test
// Self-checking bench for the probe sequence detector. Frames are driven in
// random bursts while the result side stalls on its own pattern. A bit-exact
// predictor of the scaling, window test, counters and level sequence runs
// alongside. Several enable/limit settings are covered, including the extremes.
// ----------------------------------------------------------------------------
module probe_sequence_detector_top_test;
	import psd_pkg::*;

	localparam int LEVEL_DIVISOR = 4;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

	// step of each sequence position, held apart from the design's table
	int step_table [SEQ_LEN] = '{1, 3, 2, 1, 2, 1, 3, 2, 1, 2, 3};

	class probe_frame_checker;
		logic [3:0] enable_mask;
		logic [3:0] counter_limit;
		logic [3:0] match_cnt [CHANNELS];
		logic [3:0] step_idx;
		out_beat_t  expected_beats [$];
		int         failures;

		function new();
			enable_mask   = 4'd15;
			counter_limit = 4'd10;
			foreach (match_cnt[i])
				match_cnt[i] = '0;
			step_idx = '0;
			failures = 0;
		endfunction

		function void set_reg(cfg_index_t idx, logic [3:0] val);
			case (idx)
				CFG_ENABLE_MASK:   enable_mask = val;
				CFG_COUNTER_LIMIT: counter_limit = val;
				default:           ;
			endcase
		endfunction

		function void note_frame(in_beat_t f);
			logic [15:0] codes [CHANNELS];
			logic [15:0] res [CHANNELS];
			logic [15:0] code;
			logic [3:0]  nxt;
			int          step, lo, hi, p, v, c, lim, lvl;
			out_beat_t   e;
			codes = '{f.sample_a, f.sample_b, f.sample_c, f.sample_d};
			step = step_table[step_idx];
			lo   = (2 * step - 1) * 128;
			hi   = (2 * step + 1) * 128;
			lim  = counter_limit;
			e.forced_mask = '0;
			for (int i = 0; i < CHANNELS; i++) begin
				code = enable_mask[i] ? codes[i] : MIDSCALE;
				p = (int'(code) - 32768) * 1552;
				v = p >>> 16;
				c = match_cnt[i];
				if (v * LEVEL_DIVISOR > lo && v * LEVEL_DIVISOR < hi)
					c = (c + 1 < lim) ? c + 1 : lim;
				else
					c = (c > 0) ? c - 1 : 0;
				match_cnt[i] = c[3:0];
				if (c > lim / 2) begin
					code = MIDSCALE;
					e.forced_mask[i] = 1'b1;
				end
				res[i] = code;
			end
			e.result_a = res[0];
			e.result_b = res[1];
			e.result_c = res[2];
			e.result_d = res[3];
			nxt = (step_idx >= SEQ_LEN - 1) ? 4'd0 : step_idx + 4'd1;
			step_idx = nxt;
			lvl = step_table[nxt] * 256 / LEVEL_DIVISOR;
			e.probe_level = (lvl > 255) ? 8'd255 : lvl[7:0];
			expected_beats.push_back(e);
		endfunction

		function void check_field(string name, int expv, int gotv);
			if (expv != gotv) begin
				$error("%s: expected %0d, got %0d", name, expv, gotv);
				failures++;
			end
		endfunction

		function void check_result(out_beat_t got);
			out_beat_t e;
			if (expected_beats.size() == 0) begin
				$error("result beat with no frame pending");
				failures++;
				return;
			end
			e = expected_beats.pop_front();
			check_field("result_a", e.result_a, got.result_a);
			check_field("result_b", e.result_b, got.result_b);
			check_field("result_c", e.result_c, got.result_c);
			check_field("result_d", e.result_d, got.result_d);
			check_field("forced_mask", e.forced_mask, got.forced_mask);
			check_field("probe_level", e.probe_level, got.probe_level);
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_beat_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_beat_t   out_data;
	logic        cfg_write = 1'b0;
	cfg_index_t  cfg_index = CFG_ENABLE_MASK;
	logic [3:0]  cfg_data = '0;

	probe_frame_checker frame_chk;
	int                 frames_sent = 0;
	stall_mode_t        stall_mode = STALL_NONE;
	int                 stall_left = 0;

	probe_sequence_detector_top #(
		.LEVEL_DIVISOR(LEVEL_DIVISOR)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				frame_chk.note_frame(in_data);
			if (out_valid && !out_stall)
				frame_chk.check_result(out_data);
		end
	end

	// receiver back-pressure: modes of random length, one of them stall-free
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_left <= $urandom_range(16, 160);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
			default:     out_stall <= ($urandom_range(0, 99) < 85);
		endcase
	end

	// smallest code whose scaled probe value is v (v >= 0)
	function automatic logic [15:0] code_for_v(int v);
		int d;
		d = (v * 65536 + 1551) / 1552;
		return 16'(32768 + d);
	endfunction

	function automatic int next_step();
		return step_table[frames_sent % SEQ_LEN];
	endfunction

	task automatic send_codes(input logic [15:0] a, b, c, d);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= in_beat_t'{a, b, c, d};
		frames_sent++;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic idle_input(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [3:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		frame_chk.set_reg(idx, val);
	endtask

	// wait out every pending result, then the pipeline latency
	task automatic drain();
		int waited;
		waited = 0;
		idle_input(1);
		while (frame_chk.pending() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (frame_chk.pending() != 0) begin
			$error("%0d results never arrived", frame_chk.pending());
			frame_chk.failures++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic directed_frames();
		int s;
		send_codes(16'd0, 16'd65535, 16'd32768, 16'd32767);
		send_codes(16'd65535, 16'd0, 16'd1, 16'd32769);
		send_codes(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
		// window edges across one full sequence: inside on a/b, just outside on c/d
		for (int i = 0; i < SEQ_LEN; i++) begin
			s = next_step();
			send_codes(code_for_v(s * 64 - 31), code_for_v(s * 64 + 31),
				code_for_v(s * 64 - 32), code_for_v(s * 64 + 32));
		end
		// keep a/b matching so their counters saturate and force
		for (int i = 0; i < 8; i++) begin
			s = next_step();
			send_codes(code_for_v(s * 64), code_for_v(s * 64 + 10),
				16'(32768 - 2000), 16'd65535);
		end
	endtask

	task automatic run_setting(input logic [3:0] mask, input logic [3:0] limit, input int n);
		int          sent, burst, s, r;
		int          hit_pct [CHANNELS];
		logic [15:0] c [CHANNELS];
		write_reg(CFG_ENABLE_MASK, mask);
		write_reg(CFG_COUNTER_LIMIT, limit);
		foreach (hit_pct[i])
			hit_pct[i] = 90;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 3) == 0) begin
				foreach (hit_pct[i]) begin
					case ($urandom_range(0, 5))
						0:       hit_pct[i] = 0;
						1:       hit_pct[i] = 30;
						2:       hit_pct[i] = 60;
						3:       hit_pct[i] = 85;
						4:       hit_pct[i] = 95;
						default: hit_pct[i] = 100;
					endcase
				end
			end
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < n; k++) begin
				s = next_step();
				for (int i = 0; i < CHANNELS; i++) begin
					r = $urandom_range(0, 99);
					if (r < hit_pct[i])
						c[i] = code_for_v(s * 64 - 31 + $urandom_range(0, 62));
					else if (r % 3 == 0)
						c[i] = code_for_v(($urandom_range(0, 1) != 0) ? s * 64 + 32 : s * 64 - 32);
					else if (r % 3 == 1)
						c[i] = code_for_v(step_table[$urandom_range(0, SEQ_LEN - 1)] * 64
							- 31 + $urandom_range(0, 62));
					else
						c[i] = 16'($urandom_range(0, 65535));
				end
				send_codes(c[0], c[1], c[2], c[3]);
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 8));
		end
		drain();
	endtask

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		frame_chk = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed_frames();
		drain();

		run_setting(4'd15, 4'd15, 215);
		// limit dropped below the saturated counters
		run_setting(4'd15, 4'd2, 215);
		run_setting(4'd0, 4'd7, 215);
		run_setting(4'd15, 4'd0, 215);
		run_setting(4'd5, 4'd1, 215);
		run_setting(4'd10, 4'd9, 215);
		run_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 215);
		run_setting(4'($urandom_range(0, 15)), 4'($urandom_range(2, 15)), 215);

		if (frame_chk.failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
design/psd_pkg.sv
design/psd_lane.sv
design/probe_sequence_detector_top.sv
tb/probe_sequence_detector_top_test.sv
